// File: sv/pnbc_pkg.sv
// pnbc_pkg: shared constants, types and helper functions of the pn binary correlator
// no dependencies; imported by the channel interfaces and every module of the block
package pnbc_pkg;

  localparam int WORD_BITS  = 32;
  localparam int BITCNT_W   = $clog2(WORD_BITS + 1);
  localparam int CORR_W     = 8;
  localparam int CHIP_PAT_W = 64;
  localparam int CHIP_CNT_W = 7;
  localparam int OVS_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHIP_PATTERN = 2'd0,
    CFG_CHIP_COUNT   = 2'd1,
    CFG_OVERSAMPLE   = 2'd2
  } cfg_idx_t;

  // pipeline step controls seen by every cell
  typedef struct packed {
    logic adv;
    logic push;
  } cell_ctl_t;

  // swar population count of one byte
  function automatic logic [3:0] popcnt8(input logic [7:0] x);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    a = (x & 8'h55) + ((x >> 1) & 8'h55);
    b = (a & 8'h33) + ((a >> 2) & 8'h33);
    c = (b & 8'h0F) + ((b >> 4) & 8'h0F);
    return c[3:0];
  endfunction

endpackage

// File: sv/pnbc_if.sv
// pnbc_if: valid/ready channel interfaces for sample words, results and register writes
// depends on pnbc_pkg for payload widths
interface pnbc_in_if;
  import pnbc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] sample_word;
  modport source (output valid, output sample_word, input ready);
  modport sink   (input valid, input sample_word, output ready);
endinterface

interface pnbc_out_if;
  import pnbc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CORR_W-1:0] correlation;
  logic                     last_of_word;
  modport source (output valid, output correlation, output last_of_word, input ready);
  modport sink   (input valid, input correlation, input last_of_word, output ready);
endinterface

interface pnbc_cfg_if;
  import pnbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/pnbc_cell.sv
// pnbc_cell: one chip slot of the correlator chain, a slice of the sample history
// plus the mismatch flag of its chip; depends on pnbc_pkg
module pnbc_cell #(
  parameter int MAX_OVERSAMPLE = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pnbc_pkg::cell_ctl_t        ctl,
  input  logic                       sin,
  input  logic [MAX_OVERSAMPLE-1:0]  cand,
  input  logic [((MAX_OVERSAMPLE > 1) ? $clog2(MAX_OVERSAMPLE) : 1)-1:0] os_idx,
  input  logic                       ref_bit,
  input  logic                       en_bit,
  output logic [MAX_OVERSAMPLE-1:0]  seg,
  output logic                       sout,
  output logic                       mism
);
  import pnbc_pkg::*;

  logic [MAX_OVERSAMPLE-1:0] seg_r;
  logic [MAX_OVERSAMPLE-1:0] seg_nxt;
  logic [MAX_OVERSAMPLE:0]   shift_w;
  logic                      mism_r;
  logic                      mism_nxt;

  assign shift_w  = {seg_r, sin};
  assign seg_nxt  = shift_w[MAX_OVERSAMPLE-1:0];
  // tap for the current oversample factor may sit in this cell or in another cell of the chain
  assign mism_nxt = en_bit & (ref_bit ^ cand[os_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= '0;
    end else if (ctl.push) begin
      seg_r <= seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      mism_r <= mism_nxt;
    end
  end

  assign seg  = seg_r;
  assign sout = seg_r[MAX_OVERSAMPLE-1];
  assign mism = mism_r;

endmodule

// File: sv/pnbc_sum.sv
// pnbc_sum: registered two-level count of chip mismatches and the output register
// depends on pnbc_pkg (popcnt8, result width)
module pnbc_sum #(
  parameter int MAX_CHIPS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pnbc_pkg::cell_ctl_t                ctl,
  input  logic [MAX_CHIPS-1:0]               mism,
  input  logic                               in_valid,
  input  logic                               in_last,
  input  logic [$clog2(MAX_CHIPS + 1)-1:0]   cc,
  output logic                               out_valid,
  output logic signed [pnbc_pkg::CORR_W-1:0] out_corr,
  output logic                               out_last
);
  import pnbc_pkg::*;

  localparam int NGRP  = (MAX_CHIPS + 7) / 8;
  localparam int PAD_W = NGRP * 8;

  logic [PAD_W-1:0]  mism_pad;
  logic [3:0]        grp_r [NGRP];
  logic              vb_r;
  logic              lastb_r;
  logic [CORR_W-1:0] dsum;
  logic [CORR_W-1:0] corr_nxt;
  logic [CORR_W-1:0] corr_r;
  logic              ov_r;
  logic              ol_r;

  assign mism_pad = PAD_W'(mism);

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= popcnt8(mism_pad[g*8 +: 8]);
      end
    end
  end

  always_comb begin
    dsum = '0;
    for (int g = 0; g < NGRP; g++) begin
      dsum = dsum + CORR_W'(grp_r[g]);
    end
    corr_nxt = {dsum[CORR_W-2:0], 1'b0} - CORR_W'(cc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (ctl.adv) begin
      vb_r <= in_valid;
      ov_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      lastb_r <= in_last;
      ol_r    <= lastb_r;
      corr_r  <= corr_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_corr  = signed'(corr_r);
  assign out_last  = ol_r;

endmodule

// File: sv/pn_binary_correlator.sv
// pn_binary_correlator: top level, word serializer, chain of chip cells, mismatch count
// depends on pnbc_pkg, pnbc_if, pnbc_cell, pnbc_sum
//
//  channel   dir  payload                            request taken when
//  in_ch     in   sample_word[31:0]                  valid && ready
//  out_ch    out  correlation[7:0] s, last_of_word   valid && ready
//  cfg_ch    in   index[1:0], data[63:0]             valid && ready (ready always high)
//
// one result per cycle unless out_ch.ready stalls the block, set by one sample bit shifted into the
// cell chain per cycle. the next word is taken as its predecessor's last bit shifts in.
// a word's bits pass the cell history, mismatch flags, group counts and output register in turn.
// synchronous reset clears the whole sample history directly, with no clearing pass.
// out_ch.ready low with a valid result freezes the shifting serializer, the chain and the count pipeline together.
module pn_binary_correlator #(
  parameter int MAX_CHIPS      = 64,
  parameter int MAX_OVERSAMPLE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  pnbc_in_if.sink     in_ch,
  pnbc_out_if.source  out_ch,
  pnbc_cfg_if.sink    cfg_ch
);
  import pnbc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CHIPS + 1);
  localparam int OSI_W  = (MAX_OVERSAMPLE > 1) ? $clog2(MAX_OVERSAMPLE) : 1;
  localparam int HIST_W = MAX_CHIPS * MAX_OVERSAMPLE;

  // configuration registers
  logic [CHIP_PAT_W-1:0] chip_pattern_r;
  logic [CHIP_CNT_W-1:0] chip_count_r;
  logic [OVS_W-1:0]      oversample_r;

  // derived from configuration, refreshed every cycle
  logic [CNT_W-1:0]     cc_eff;
  logic [CNT_W-1:0]     cc_eff_r;
  logic [OVS_W:0]       os_eff;
  logic [OVS_W:0]       os_m1;
  logic [OSI_W-1:0]     os_idx_r;
  logic [MAX_CHIPS-1:0] rev_w;
  logic [MAX_CHIPS-1:0] aligned_r;
  logic [MAX_CHIPS-1:0] mask_r;

  // serializer and pipeline control
  logic [WORD_BITS-1:0] word_r;
  logic [BITCNT_W-1:0]  cnt_r;
  logic                 v0_r;
  logic                 last0_r;
  logic                 va_r;
  logic                 lasta_r;
  logic                 busy;
  logic                 adv;
  logic                 in_take;
  cell_ctl_t            ctl;

  logic                        out_valid;
  logic signed [CORR_W-1:0]    out_corr;
  logic                        out_last;

  logic [MAX_OVERSAMPLE-1:0] seg_w  [MAX_CHIPS];
  logic [MAX_OVERSAMPLE-1:0] cand_w [MAX_CHIPS];
  logic [MAX_CHIPS-1:0]      sout_w;
  logic [MAX_CHIPS-1:0]      mism_w;
  logic [HIST_W-1:0]         hist_w;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_pattern_r <= '0;
      chip_count_r   <= CHIP_CNT_W'(64);
      oversample_r   <= OVS_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_CHIP_PATTERN: chip_pattern_r <= cfg_ch.data[CHIP_PAT_W-1:0];
        CFG_CHIP_COUNT:   chip_count_r   <= cfg_ch.data[CHIP_CNT_W-1:0];
        CFG_OVERSAMPLE:   oversample_r   <= cfg_ch.data[OVS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chip_count_r == '0) begin
      cc_eff = CNT_W'(1);
    end else if (chip_count_r > CHIP_CNT_W'(MAX_CHIPS)) begin
      cc_eff = CNT_W'(MAX_CHIPS);
    end else begin
      cc_eff = CNT_W'(chip_count_r);
    end
    if (oversample_r == '0) begin
      os_eff = (OVS_W + 1)'(1);
    end else if ({1'b0, oversample_r} > (OVS_W + 1)'(MAX_OVERSAMPLE)) begin
      os_eff = (OVS_W + 1)'(MAX_OVERSAMPLE);
    end else begin
      os_eff = {1'b0, oversample_r};
    end
    os_m1 = os_eff - (OVS_W + 1)'(1);
    for (int i = 0; i < MAX_CHIPS; i++) begin
      rev_w[i] = chip_pattern_r[MAX_CHIPS-1-i];
    end
  end

  // cell j compares against chip cc-1-j, cells at or above cc stay silent
  always_ff @(posedge clk) begin
    cc_eff_r  <= cc_eff;
    os_idx_r  <= OSI_W'(os_m1);
    aligned_r <= rev_w >> (CNT_W'(MAX_CHIPS) - cc_eff);
    mask_r    <= ~({MAX_CHIPS{1'b1}} << cc_eff);
  end

  // ---------------- word serializer ----------------
  assign busy        = (cnt_r != '0);
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = !busy || ((cnt_r == BITCNT_W'(1)) && adv);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign ctl.adv     = adv;
  assign ctl.push    = adv && busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v0_r  <= 1'b0;
      va_r  <= 1'b0;
    end else begin
      if (in_take) begin
        cnt_r <= BITCNT_W'(WORD_BITS);
      end else if (ctl.push) begin
        cnt_r <= cnt_r - BITCNT_W'(1);
      end
      if (adv) begin
        v0_r <= busy;
        va_r <= v0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      word_r <= in_ch.sample_word;
    end else if (ctl.push) begin
      word_r <= word_r << 1;
    end
    if (adv) begin
      last0_r <= (cnt_r == BITCNT_W'(1));
      lasta_r <= last0_r;
    end
  end

  // ---------------- cell chain ----------------
  for (genvar j = 0; j < MAX_CHIPS; j++) begin : g_cell
    assign hist_w[j*MAX_OVERSAMPLE +: MAX_OVERSAMPLE] = seg_w[j];
    for (genvar o = 0; o < MAX_OVERSAMPLE; o++) begin : g_tap
      assign cand_w[j][o] = hist_w[(j + 1) * (o + 1) - 1];
    end

    pnbc_cell #(
      .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .sin     ((j == 0) ? word_r[WORD_BITS-1] : sout_w[(j == 0) ? 0 : j - 1]),
      .cand    (cand_w[j]),
      .os_idx  (os_idx_r),
      .ref_bit (aligned_r[j]),
      .en_bit  (mask_r[j]),
      .seg     (seg_w[j]),
      .sout    (sout_w[j]),
      .mism    (mism_w[j])
    );
  end

  // ---------------- mismatch count ----------------
  pnbc_sum #(
    .MAX_CHIPS (MAX_CHIPS)
  ) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .mism      (mism_w),
    .in_valid  (va_r),
    .in_last   (lasta_r),
    .cc        (cc_eff_r),
    .out_valid (out_valid),
    .out_corr  (out_corr),
    .out_last  (out_last)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.correlation  = out_corr;
  assign out_ch.last_of_word = out_last;

  // ---------------- assertions ----------------
  a_load_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (cnt_r == BITCNT_W'(WORD_BITS)))
    else $error("accepted word did not load a full bit count");

  a_hist_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(hist_w))
    else $error("sample history moved during an output stall");

  a_corr_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_corr[0] == cc_eff_r[0]))
    else $error("correlation parity disagrees with chip count");

endmodule
